// ----- hw/rtl/asmc_pkg.sv -----
// Shared types, register indexes and helper functions for the surge/yaw controller.
// No dependencies; imported by asmc_alu, asmc_isqrt and the top level.
package asmc_pkg;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    localparam int CFG_NUM = 8;
    localparam logic [2:0] CFG_SPEED_RATE    = 3'd0;
    localparam logic [2:0] CFG_HEADING_RATE  = 3'd1;
    localparam logic [2:0] CFG_SPEED_FLOOR   = 3'd2;
    localparam logic [2:0] CFG_HEADING_FLOOR = 3'd3;
    localparam logic [2:0] CFG_SPEED_LIN     = 3'd4;
    localparam logic [2:0] CFG_HEADING_LIN   = 3'd5;
    localparam logic [2:0] CFG_SPEED_SLOPE   = 3'd6;
    localparam logic [2:0] CFG_HEADING_SLOPE = 3'd7;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        if (x < lo) begin
            return lo;
        end else if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

    // fold an angle difference into +-pi
    function automatic logic signed [31:0] wrap_pi(input logic signed [33:0] e,
                                                   input logic signed [33:0] pi_c,
                                                   input logic signed [33:0] two_pi_c);
        logic signed [33:0] a;
        a = (e < 0) ? -e : e;
        if (a > pi_c) begin
            return (e > 0) ? 32'(a - two_pi_c) : 32'(two_pi_c - a);
        end
        return e[31:0];
    endfunction

    function automatic logic signed [31:0] gain_rate(input logic signed [31:0] gain,
                                                     input logic [23:0] floor_v,
                                                     input logic [23:0] rate,
                                                     input logic signed [31:0] sigma,
                                                     input logic signed [33:0] mu);
        logic signed [33:0] d;
        d = ((sigma < 0) ? -34'(sigma) : 34'(sigma)) - mu;
        if (gain <= $signed(32'(floor_v))) begin
            return 32'(floor_v);
        end else if (d > 0) begin
            return 32'(rate);
        end else if (d < 0) begin
            return -$signed(32'(rate));
        end
        return 32'sd0;
    endfunction

endpackage

// ----- hw/rtl/asmc_alu.sv -----
// Shared arithmetic unit: rounded fixed-point multiply or add/subtract, saturated to 32 bits.
// Depends on asmc_pkg.
module asmc_alu import asmc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  t_alu_op            i_op,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [31:0] o_res,
    output logic signed [63:0] o_prod,
    output logic signed [34:0] o_sum
);
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] w_rnd;

    assign o_prod = $signed(i_a[31:0]) * $signed(i_b[31:0]);
    assign w_rnd  = (o_prod + HALF_LSB) >>> FRAC_BITS;

    always_comb begin
        o_sum = 35'(i_a) + 35'(i_b);
        o_res = sat32(64'(o_sum));
        case (i_op)
            ALU_ADD: begin
                o_sum = 35'(i_a) + 35'(i_b);
                o_res = sat32(64'(o_sum));
            end
            ALU_SUB: begin
                o_sum = 35'(i_a) - 35'(i_b);
                o_res = sat32(64'(o_sum));
            end
            ALU_MUL: begin
                o_res = sat32(w_rnd);
            end
            default: begin
                o_res = 32'sd0;
            end
        endcase
    end
endmodule

// ----- hw/rtl/asmc_isqrt.sv -----
// Floor square root of a 64-bit word, one result bit per cycle.
// Depends on asmc_pkg.
module asmc_isqrt import asmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] w_rem_sh;
    logic [34:0] w_trial;

    assign w_rem_sh = {r_rem[32:0], r_x[63:62]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[61:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- hw/rtl/adaptive_sliding_mode_surge_yaw_control.sv -----
// Top level of the adaptive super-twisting surge/yaw controller: sequencer, state, outputs.
// Depends on asmc_pkg, asmc_alu and asmc_isqrt.
//
//  channel | direction | handshake                 | word
//  in      | in        | i_in_valid / o_in_ready   | speeds, headings, enable flags
//  out     | out       | o_out_valid / i_out_ready | thrusts, force, moment, gains, errors, surfaces
//  cfg     | in        | i_cfg_valid / o_cfg_ready | register index and value
//
// An enabled tick runs from accept to the next accept through 61 steps, most of them through
// the shared multiply/add unit, three square roots and one hand-off state.
// The result word is registered as the hand-off state ends. A disabled tick is taken and
// dropped. Synchronous active-low reset clears state and loads register defaults.
// The next word is taken while a finished result waits; a new result waits for i_out_ready.
module adaptive_sliding_mode_surge_yaw_control import asmc_pkg::*; #(
    parameter int MU_SPEED   = 3277,
    parameter int MU_HEADING = 6554,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_surge_speed,
    input  logic signed [23:0] i_sway_speed,
    input  logic signed [23:0] i_yaw_rate,
    input  logic signed [19:0] i_heading,
    input  logic signed [23:0] i_target_speed,
    input  logic signed [19:0] i_target_heading,
    input  logic               i_test_mode,
    input  logic               i_link_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [22:0] o_starboard_thrust,
    output logic signed [22:0] o_port_thrust,
    output logic signed [23:0] o_surge_force,
    output logic signed [20:0] o_yaw_moment,
    output logic signed [31:0] o_speed_adaptive_gain,
    output logic signed [31:0] o_heading_adaptive_gain,
    output logic signed [31:0] o_speed_error,
    output logic signed [19:0] o_heading_error,
    output logic signed [31:0] o_speed_surface,
    output logic signed [31:0] o_heading_surface,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    localparam longint ONE_C    = longint'(1) <<< FRAC_BITS;
    localparam longint HALF_DT  = (ONE_C + 100) / 200;
    localparam longint INV_DT   = 100 * ONE_C;
    localparam longint DRAG_SW  = (6 * ONE_C + 2) / 5;
    localparam longint XU_LOW   = -(25 * ONE_C);
    localparam longint XU_HIGH  = (6455 * ONE_C + 50) / 100;
    localparam longint XUU_HIGH = -((7092 * ONE_C + 50) / 100);
    localparam longint NR_COEF  = -((52 * ONE_C + 50) / 100);
    localparam longint SURGE_M  = (3225 * ONE_C + 50) / 100;
    localparam longint SWAY_M   = (5313 * ONE_C + 50) / 100;
    localparam longint YAW_I    = (689 * ONE_C + 50) / 100;
    localparam longint CROSS_C  = -((2088 * ONE_C + 50) / 100);
    localparam longint PI_C     = (3141592 * ONE_C + 500000) / 1000000;
    localparam longint TWO_PI_C = (6283184 * ONE_C + 500000) / 1000000;
    localparam longint FILT_G   = 4 * ONE_C;
    localparam longint TX_MAX   = 73 * ONE_C;
    localparam longint TX_MIN   = -(60 * ONE_C);
    localparam longint TZ_LIM   = 14 * ONE_C;
    localparam longint TH_MAX   = (73 * ONE_C + 1) / 2;
    localparam longint TH_MIN   = -(30 * ONE_C);
    localparam longint INV_BEAM = (100 * ONE_C + 20) / 41;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [5:0] PC_SQRT_NORM  = 6'd2;
    localparam logic [5:0] PC_SQRT_SPEED = 6'd44;
    localparam logic [5:0] PC_SQRT_HEAD  = 6'd48;
    localparam logic [5:0] PC_LAST       = 6'd63;

    logic [1:0] r_state;
    logic [5:0] r_pc;
    logic       r_sq_wait;
    logic [23:0] r_cfg [CFG_NUM];

    logic signed [23:0] r_u, r_v, r_r, r_ud;
    logic signed [19:0] r_th, r_psid;
    logic [63:0]        r_rad;
    logic [31:0]        r_root;
    logic signed [33:0] r_fu;
    logic signed [31:0] r_t1, r_t2, r_nr, r_fpsi, r_eu, r_epsi, r_dif, r_rd;
    logic signed [31:0] r_accn, r_veln, r_posn, r_epsid, r_su, r_spsi, r_ru, r_rpsi;
    logic signed [31:0] r_uau, r_uapsi, r_tx, r_tz, r_tb, r_port, r_stbd;
    logic signed [31:0] r_integ, r_eprev, r_href, r_fpos, r_fvel, r_facc;
    logic signed [31:0] r_sg, r_hg, r_sgrp, r_hgrp;

    t_alu_op            w_op;
    logic signed [33:0] w_a, w_b;
    logic signed [31:0] w_res;
    logic signed [63:0] w_prod;
    logic signed [34:0] w_sum;
    logic               w_is_sqrt;
    logic               w_sq_start;
    logic               w_sq_done;
    logic [31:0]        w_sq_root;
    logic [63:0]        w_sq_rad;
    logic signed [33:0] w_uabs;
    logic               w_fast;
    logic signed [33:0] w_tsgn;
    logic signed [33:0] w_half;
    logic               w_in_acc;
    logic               w_enabled;
    logic               w_advance;
    logic               w_out_free;

    function automatic logic [63:0] abs_shift(input logic signed [31:0] s);
        logic [32:0] a;
        a = (s < 0) ? 33'(-34'(s)) : 33'(s);
        return 64'(a) << FRAC_BITS;
    endfunction

    function automatic logic signed [33:0] twist_sign(input logic signed [31:0] s,
                                                      input logic signed [31:0] t);
        if (s > 0) begin
            return -34'(t);
        end else if (s < 0) begin
            return 34'(t);
        end
        return 34'sd0;
    endfunction

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_enabled  = i_test_mode && i_link_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    assign w_uabs = r_u[23] ? -34'(r_u) : 34'(r_u);
    assign w_fast = w_uabs > 34'(DRAG_SW);
    assign w_half = 34'(r_tx >>> 1);

    assign w_is_sqrt = (r_pc == PC_SQRT_NORM) || (r_pc == PC_SQRT_SPEED) ||
                       (r_pc == PC_SQRT_HEAD);
    assign w_sq_start = (r_state == ST_RUN) && w_is_sqrt && !r_sq_wait;
    assign w_advance  = (r_state == ST_RUN) && (!w_is_sqrt || w_sq_done);

    always_comb begin
        case (r_pc)
            PC_SQRT_SPEED: w_sq_rad = abs_shift(r_su);
            PC_SQRT_HEAD:  w_sq_rad = abs_shift(r_spsi);
            default:       w_sq_rad = r_rad;
        endcase
    end

    assign w_tsgn = (r_pc == 6'd47) ? twist_sign(r_su, r_t1) : twist_sign(r_spsi, r_t1);

    // operand select for the shared unit
    always_comb begin
        w_op = ALU_MUL;
        w_a  = '0;
        w_b  = '0;
        case (r_pc)
            6'd0:  begin w_a = 34'(r_u); w_b = 34'(r_u); end
            6'd1:  begin w_a = 34'(r_v); w_b = 34'(r_v); end
            6'd3:  begin w_a = 34'(NR_COEF); w_b = 34'(r_root); end
            6'd4:  begin w_a = 34'(r_v); w_b = 34'(r_r); end
            6'd5:  begin w_a = 34'(SWAY_M); w_b = 34'(r_t1); end
            6'd6:  begin w_a = w_uabs; w_b = 34'(r_u); end
            6'd7:  begin w_a = w_fast ? 34'(XUU_HIGH) : 34'sd0; w_b = 34'(r_t1); end
            6'd8:  begin w_op = ALU_ADD; w_a = r_fu; w_b = 34'(r_t1); end
            6'd9:  begin w_a = w_fast ? 34'(XU_HIGH) : 34'(XU_LOW); w_b = 34'(r_u); end
            6'd10: begin w_op = ALU_ADD; w_a = r_fu; w_b = 34'(r_t1); end
            6'd11: begin w_a = 34'(r_u); w_b = 34'(r_v); end
            6'd12: begin w_a = 34'(CROSS_C); w_b = 34'(r_t1); end
            6'd13: begin w_a = 34'(r_nr); w_b = 34'(r_r); end
            6'd14: begin w_op = ALU_ADD; w_a = 34'(r_fpsi); w_b = 34'(r_t1); end
            6'd15: begin w_op = ALU_SUB; w_a = 34'(r_ud); w_b = 34'(r_u); end
            6'd16: begin w_op = ALU_SUB; w_a = 34'(r_psid); w_b = 34'(r_th); end
            6'd17: begin w_op = ALU_ADD; w_a = 34'(r_eu); w_b = 34'(r_eprev); end
            6'd18: begin w_a = 34'(r_t1); w_b = 34'(HALF_DT); end
            6'd19: begin w_op = ALU_ADD; w_a = 34'(r_t1); w_b = 34'(r_integ); end
            6'd20: begin w_op = ALU_SUB; w_a = 34'(r_psid); w_b = 34'(r_href); end
            6'd21: begin w_a = 34'(r_dif); w_b = 34'(INV_DT); end
            6'd22: begin w_op = ALU_SUB; w_a = 34'(r_rd); w_b = 34'(r_fpos); end
            6'd23: begin w_a = 34'(FILT_G); w_b = 34'(r_t1); end
            6'd24: begin w_a = 34'(FILT_G); w_b = 34'(r_fvel); end
            6'd25: begin w_op = ALU_SUB; w_a = 34'(r_accn); w_b = 34'(r_t1); end
            6'd26: begin w_op = ALU_ADD; w_a = 34'(r_accn); w_b = 34'(r_facc); end
            6'd27: begin w_a = 34'(r_t1); w_b = 34'(HALF_DT); end
            6'd28: begin w_op = ALU_ADD; w_a = 34'(r_t1); w_b = 34'(r_fvel); end
            6'd29: begin w_op = ALU_ADD; w_a = 34'(r_veln); w_b = 34'(r_fvel); end
            6'd30: begin w_a = 34'(r_t1); w_b = 34'(HALF_DT); end
            6'd31: begin w_op = ALU_ADD; w_a = 34'(r_t1); w_b = 34'(r_fpos); end
            6'd32: begin w_op = ALU_SUB; w_a = 34'(r_posn); w_b = 34'(r_r); end
            6'd33: begin w_a = 34'(r_cfg[CFG_SPEED_SLOPE]); w_b = 34'(r_integ); end
            6'd34: begin w_op = ALU_ADD; w_a = 34'(r_eu); w_b = 34'(r_t1); end
            6'd35: begin w_a = 34'(r_cfg[CFG_HEADING_SLOPE]); w_b = 34'(r_epsi); end
            6'd36: begin w_op = ALU_ADD; w_a = 34'(r_epsid); w_b = 34'(r_t1); end
            6'd38: begin w_op = ALU_ADD; w_a = 34'(r_ru); w_b = 34'(r_sgrp); end
            6'd39: begin w_a = 34'(r_t1); w_b = 34'(HALF_DT); end
            6'd40: begin w_op = ALU_ADD; w_a = 34'(r_t1); w_b = 34'(r_sg); end
            6'd41: begin w_op = ALU_ADD; w_a = 34'(r_rpsi); w_b = 34'(r_hgrp); end
            6'd42: begin w_a = 34'(r_t1); w_b = 34'(HALF_DT); end
            6'd43: begin w_op = ALU_ADD; w_a = 34'(r_t1); w_b = 34'(r_hg); end
            6'd45: begin w_a = 34'(r_sg); w_b = 34'(r_root); end
            6'd46: begin w_a = 34'(r_cfg[CFG_SPEED_LIN]); w_b = 34'(r_su); end
            6'd47: begin w_op = ALU_SUB; w_a = w_tsgn; w_b = 34'(r_t2); end
            6'd49: begin w_a = 34'(r_hg); w_b = 34'(r_root); end
            6'd50: begin w_a = 34'(r_cfg[CFG_HEADING_LIN]); w_b = 34'(r_spsi); end
            6'd51: begin w_op = ALU_SUB; w_a = w_tsgn; w_b = 34'(r_t2); end
            6'd52: begin w_a = 34'(r_cfg[CFG_SPEED_SLOPE]); w_b = 34'(r_eu); end
            6'd53: begin w_op = ALU_SUB; w_a = 34'(r_t1); w_b = 34'(r_uau); end
            6'd54: begin w_a = 34'(SURGE_M); w_b = 34'(r_t1); end
            6'd55: begin w_op = ALU_SUB; w_a = 34'(r_t1); w_b = r_fu; end
            6'd56: begin w_a = 34'(r_cfg[CFG_HEADING_SLOPE]); w_b = 34'(r_epsid); end
            6'd57: begin w_op = ALU_SUB; w_a = 34'(r_t1); w_b = 34'(r_uapsi); end
            6'd58: begin w_a = 34'(YAW_I); w_b = 34'(r_t1); end
            6'd59: begin w_op = ALU_SUB; w_a = 34'(r_t1); w_b = 34'(r_fpsi); end
            6'd61: begin w_a = 34'(r_tz); w_b = 34'(INV_BEAM); end
            6'd62: begin w_op = ALU_ADD; w_a = w_half; w_b = 34'(r_tb); end
            6'd63: begin w_op = ALU_SUB; w_a = w_half; w_b = 34'(r_tb); end
            default: begin
                w_op = ALU_MUL;
            end
        endcase
    end

    asmc_alu #(
        .FRAC_BITS(FRAC_BITS)
    ) u_alu (
        .i_op   (w_op),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_res  (w_res),
        .o_prod (w_prod),
        .o_sum  (w_sum)
    );

    asmc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_sq_rad),
        .o_done     (w_sq_done),
        .o_root     (w_sq_root)
    );

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_sq_wait <= 1'b0;
            o_out_valid <= 1'b0;
            r_cfg[CFG_SPEED_RATE]    <= 24'd6554;
            r_cfg[CFG_HEADING_RATE]  <= 24'd13107;
            r_cfg[CFG_SPEED_FLOOR]   <= 24'd3277;
            r_cfg[CFG_HEADING_FLOOR] <= 24'd13107;
            r_cfg[CFG_SPEED_LIN]     <= 24'd1311;
            r_cfg[CFG_HEADING_LIN]   <= 24'd6554;
            r_cfg[CFG_SPEED_SLOPE]   <= 24'd66;
            r_cfg[CFG_HEADING_SLOPE] <= 24'd65536;
        end else begin
            if (i_cfg_valid) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            // a new result replaces the taken one in the same cycle
            if (r_state == ST_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (w_sq_start) begin
                r_sq_wait <= 1'b1;
            end else if (w_sq_done) begin
                r_sq_wait <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && w_enabled) begin
                        r_state <= ST_RUN;
                        r_pc    <= '0;
                    end
                end
                ST_RUN: begin
                    if (w_advance) begin
                        r_pc <= r_pc + 6'd1;
                        if (r_pc == PC_LAST) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0; r_eprev <= '0; r_href <= '0;
            r_fpos  <= '0; r_fvel  <= '0; r_facc <= '0;
            r_sg    <= '0; r_hg    <= '0; r_sgrp <= '0; r_hgrp <= '0;
        end else if (w_advance) begin
            case (r_pc)
                6'd19: begin r_integ <= w_res; r_eprev <= r_eu; end
                6'd21: r_href <= 32'(r_psid);
                6'd32: begin r_facc <= r_accn; r_fvel <= r_veln; r_fpos <= r_posn; end
                6'd40: begin r_sg <= w_res; r_sgrp <= r_ru; end
                6'd43: begin r_hg <= w_res; r_hgrp <= r_rpsi; end
                6'd60: begin
                    if (r_ud == 24'sd0) begin
                        r_integ <= '0; r_eprev <= '0;
                        r_fpos  <= '0; r_fvel  <= '0; r_facc <= '0;
                        r_sg    <= '0; r_hg    <= '0; r_sgrp <= '0; r_hgrp <= '0;
                    end
                end
                default: begin
                    r_integ <= r_integ;
                end
            endcase
        end
    end

    // working values
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_u    <= i_surge_speed;
            r_v    <= i_sway_speed;
            r_r    <= i_yaw_rate;
            r_th   <= i_heading;
            r_ud   <= i_target_speed;
            r_psid <= i_target_heading;
        end
        if (w_advance) begin
            case (r_pc)
                6'd0:  r_rad <= 64'(w_prod);
                6'd1:  r_rad <= r_rad + 64'(w_prod);
                6'd2:  r_root <= w_sq_root;
                6'd3:  r_nr <= w_res;
                6'd5:  r_fu <= 34'(w_res);
                6'd8:  r_fu <= w_sum[33:0];
                6'd10: r_fu <= 34'(w_res);
                6'd12: r_fpsi <= w_res;
                6'd14: r_fpsi <= w_res;
                6'd15: r_eu <= w_res;
                6'd16: r_epsi <= wrap_pi(w_sum[33:0], 34'(PI_C), 34'(TWO_PI_C));
                6'd20: r_dif <= wrap_pi(w_sum[33:0], 34'(PI_C), 34'(TWO_PI_C));
                6'd21: r_rd <= w_res;
                6'd23: r_accn <= w_res;
                6'd25: r_accn <= w_res;
                6'd28: r_veln <= w_res;
                6'd31: r_posn <= w_res;
                6'd32: r_epsid <= w_res;
                6'd34: r_su <= w_res;
                6'd36: r_spsi <= w_res;
                6'd37: begin
                    r_ru <= gain_rate(r_sg, r_cfg[CFG_SPEED_FLOOR], r_cfg[CFG_SPEED_RATE],
                                      r_su, 34'(MU_SPEED));
                    r_rpsi <= gain_rate(r_hg, r_cfg[CFG_HEADING_FLOOR],
                                        r_cfg[CFG_HEADING_RATE], r_spsi, 34'(MU_HEADING));
                end
                6'd44: r_root <= w_sq_root;
                6'd46: r_t2 <= w_res;
                6'd47: r_uau <= w_res;
                6'd48: r_root <= w_sq_root;
                6'd50: r_t2 <= w_res;
                6'd51: r_uapsi <= w_res;
                6'd55: r_tx <= clamp32(w_res, 32'(TX_MIN), 32'(TX_MAX));
                6'd59: r_tz <= clamp32(w_res, -32'(TZ_LIM), 32'(TZ_LIM));
                6'd60: begin
                    if (r_ud == 24'sd0) begin
                        r_tx <= '0;
                        r_tz <= '0;
                    end
                end
                6'd61: r_tb <= w_res;
                6'd62: r_port <= clamp32(w_res, 32'(TH_MIN), 32'(TH_MAX));
                6'd63: r_stbd <= clamp32(w_res, 32'(TH_MIN), 32'(TH_MAX));
                default: r_t1 <= w_res;
            endcase
        end
    end

    // result word, held until taken
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            o_starboard_thrust      <= r_stbd[22:0];
            o_port_thrust           <= r_port[22:0];
            o_surge_force           <= r_tx[23:0];
            o_yaw_moment            <= r_tz[20:0];
            o_speed_adaptive_gain   <= r_sg;
            o_heading_adaptive_gain <= r_hg;
            o_speed_error           <= r_eu;
            o_heading_error         <= r_epsi[19:0];
            o_speed_surface         <= r_su;
            o_heading_surface       <= r_spsi;
        end
    end
endmodule

// ----- hw/rtl/asmc_checker.sv -----
// Port-level checks for the surge/yaw controller, bound to the top level.
// Depends on adaptive_sliding_mode_surge_yaw_control ports only.
module asmc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_test_mode,
    input logic               i_link_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [22:0] o_port_thrust,
    input logic signed [22:0] o_starboard_thrust,
    input logic signed [20:0] o_yaw_moment
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before taken");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_test_mode && i_link_ready |=> !o_in_ready)
        else $error("enabled tick did not start work");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !(i_test_mode && i_link_ready) |=> o_in_ready)
        else $error("disabled tick started work");

    a_thrust_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_port_thrust >= -23'sd1966080 && o_port_thrust <= 23'sd2392064 &&
        o_starboard_thrust >= -23'sd1966080 && o_starboard_thrust <= 23'sd2392064)
        else $error("thrust outside limits");

    a_moment_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_yaw_moment >= -21'sd917504 && o_yaw_moment <= 21'sd917504)
        else $error("yaw moment outside limits");
endmodule

bind adaptive_sliding_mode_surge_yaw_control asmc_checker u_asmc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_test_mode        (i_test_mode),
    .i_link_ready       (i_link_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_port_thrust      (o_port_thrust),
    .o_starboard_thrust (o_starboard_thrust),
    .o_yaw_moment       (o_yaw_moment)
);
